>>> hdl/cedct_pkg.sv
`timescale 1ns / 1ps

package cedct_pkg;

   // Default number of extremum points in one set.
   localparam int POINTS_DEFAULT = 33;

   // Field widths.
   localparam int SAMPLE_W = 16;
   localparam int COEFF_W  = 16;
   localparam int INDEX_W  = 6;

   // Cosine table entries are signed Q2.16, so +1.0 and -1.0 both fit.
   localparam int COS_W     = 18;
   localparam int COS_FRAC  = 16;

   // Series constants in Q2.30.
   localparam longint unsigned PI_Q30  = 64'd3373259426;
   localparam longint unsigned ONE_Q30 = 64'd1073741824;
   localparam longint unsigned Q30_TO_Q16_HALF = 64'd8192;

   // Saturation limits of a Q1.15 result, as magnitudes.
   localparam int SAT_POS_MAG = 32767;
   localparam int SAT_NEG_MAG = 32768;
   localparam logic signed [COEFF_W-1:0] SAT_POS = 16'sh7FFF;
   localparam logic signed [COEFF_W-1:0] SAT_NEG = 16'sh8000;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> hdl/cedct_store.sv
`timescale 1ns / 1ps

module cedct_store import cedct_pkg::*; #(
   parameter int POINTS = POINTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(POINTS)-1:0]         wr_addr,
   input  logic signed [SAMPLE_W-1:0]        wr_data,
   input  logic [$clog2(POINTS)-1:0]         rd_addr,
   output logic signed [SAMPLE_W-1:0]        rd_data
);

   logic signed [SAMPLE_W-1:0] mem [POINTS];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/cedct_rom.sv
`timescale 1ns / 1ps

module cedct_rom import cedct_pkg::*; #(
   parameter int POINTS = POINTS_DEFAULT
) (
   input  logic                                  clock,
   input  logic [$clog2(2*(POINTS-1))-1:0]       addr,
   output logic signed [COS_W-1:0]               data
);

   localparam int D         = POINTS - 1;
   localparam int ROM_DEPTH = 2 * D;

   logic signed [COS_W-1:0] tab [ROM_DEPTH];
   logic signed [COS_W-1:0] data_ff;

   // Entry k holds cos(pi*k/D) in Q2.16. The angle is folded into the first quadrant and
   // the cosine is built from a truncating Horner series in Q2.30.
   for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_tab
      localparam int unsigned R0  = g;
      localparam int unsigned R1  = (R0 > D) ? (2 * D - R0) : R0;
      localparam bit          NEG = (2 * R1 > D);
      localparam int unsigned R2  = NEG ? (D - R1) : R1;
      localparam longint unsigned X  = (PI_Q30 * R2 + D / 2) / D;
      localparam longint unsigned X2 = (X * X) >> 30;
      localparam longint unsigned S1 = ((X2 * ONE_Q30) >> 30) / 132;
      localparam longint unsigned T1 = (S1 > ONE_Q30) ? 0 : (ONE_Q30 - S1);
      localparam longint unsigned S2 = ((X2 * T1) >> 30) / 90;
      localparam longint unsigned T2 = (S2 > ONE_Q30) ? 0 : (ONE_Q30 - S2);
      localparam longint unsigned S3 = ((X2 * T2) >> 30) / 56;
      localparam longint unsigned T3 = (S3 > ONE_Q30) ? 0 : (ONE_Q30 - S3);
      localparam longint unsigned S4 = ((X2 * T3) >> 30) / 30;
      localparam longint unsigned T4 = (S4 > ONE_Q30) ? 0 : (ONE_Q30 - S4);
      localparam longint unsigned S5 = ((X2 * T4) >> 30) / 12;
      localparam longint unsigned T5 = (S5 > ONE_Q30) ? 0 : (ONE_Q30 - S5);
      localparam longint unsigned S6 = ((X2 * T5) >> 30) / 2;
      localparam longint unsigned T6 = (S6 > ONE_Q30) ? 0 : (ONE_Q30 - S6);
      localparam longint unsigned V  = (T6 + Q30_TO_Q16_HALF) >> 14;
      localparam longint unsigned VS = NEG ? (64'd0 - V) : V;

      assign tab[g] = COS_W'(VS);
   end

   always_ff @(posedge clock) begin
      data_ff <= tab[addr];
   end

   assign data = data_ff;

endmodule

>>> hdl/cedct_div.sv
`timescale 1ns / 1ps

module cedct_div import cedct_pkg::*; #(
   parameter int NUM_W   = 24,
   parameter int DIVISOR = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     numer,
   output logic [NUM_W-1:0]     quotient,
   output div_status_type       status
);

   // Division by a constant as a multiplication by its rounded-up reciprocal. With the
   // shift set to NUM_W plus the bits of the divisor, the upper bits of the product are the
   // exact floor quotient for every NUM_W-bit dividend.
   localparam int              SHIFT   = NUM_W + $clog2(DIVISOR);
   localparam int              RECIP_W = NUM_W + 1;
   localparam int              PROD_W  = NUM_W + RECIP_W;
   localparam longint unsigned RECIP   = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;

   logic [NUM_W-1:0]  num_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              busy_ff;
   logic              done_ff;

   // The dividend is registered with start, the product while busy is high; done follows busy.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= start;
         done_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= numer;
      end
      if (busy_ff) begin
         prod_ff <= PROD_W'(num_ff) * PROD_W'(RECIP_W'(RECIP));
      end
   end

   assign quotient    = NUM_W'(prod_ff[PROD_W-1:SHIFT]);
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

>>> hdl/chebyshev_extrema_coeffs_dct1.sv
`timescale 1ns / 1ps

// Normalised type-1 DCT over samples taken at the Chebyshev extrema.
//
// The request channel carries one signed Q1.15 sample per word. POINTS words make a set;
// they are written in order into a sample memory, at most one per cycle. When the word that
// completes the set has been taken, the request side stalls and the block produces POINTS
// response words, coefficient 0 first, each carrying its index, the saturated Q1.15
// coefficient and a flag that is high on the final word of the set.
//
// Each coefficient is a multiply-accumulate pass over the interior samples with one shared
// multiplier, followed by an end-point correction, rounding and a divide by 2*(POINTS-1)
// done as a multiplication by its reciprocal. A coefficient goes through the pass and its
// pipeline, then through scaling, division and hand-over.
//
// The response word sits in an output register, so a stalled receiver only delays the
// hand-over of the next finished coefficient. Once the last word of a set is in the output
// register, samples of the next set are taken again. Reset empties the output register and
// starts a fresh set; the sample memory is not cleared, as every entry is written first.

module chebyshev_extrema_coeffs_dct1 import cedct_pkg::*; #(
   parameter int POINTS = POINTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [INDEX_W-1:0]         rsp_coeff_index,
   output logic signed [COEFF_W-1:0]  rsp_coefficient,
   output logic                       rsp_last_coeff
);

   localparam int D       = POINTS - 1;
   localparam int AW      = $clog2(POINTS);
   localparam int ROM_AW  = $clog2(2 * D);
   localparam int PROD_W  = SAMPLE_W + COS_W;
   localparam int ACC_W   = 34 + AW;
   localparam int NUM_W   = ACC_W - COS_FRAC;
   localparam int END_W   = SAMPLE_W + 1;
   localparam logic [ACC_W-1:0] RND = ACC_W'(D) << COS_FRAC;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MAC,
      ST_FIN,
      ST_ABS,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type                  st_ff;
   logic [AW-1:0]              ld_cnt_ff;
   logic signed [SAMPLE_W-1:0] s0_ff;
   logic signed [END_W-1:0]    end_even_ff;
   logic signed [END_W-1:0]    end_odd_ff;
   logic [AW-1:0]              idx_ff;
   logic [AW-1:0]              j_ff;
   logic [ROM_AW-1:0]          phase_ff;
   logic [ROM_AW-1:0]          phase_in;
   logic [ROM_AW:0]            phase_sum;
   logic                       issue_ff;
   logic                       rd_vld_ff;
   logic                       prod_vld_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [END_W-1:0]    ends;
   logic [ACC_W-1:0]           mag_ff;
   logic [ACC_W-1:0]           rnd_sum;
   logic                       neg_ff;
   logic                       div_start_ff;
   logic                       req_take;
   logic                       out_free;

   logic                       rsp_valid_ff;
   logic [INDEX_W-1:0]         rsp_index_ff;
   logic signed [COEFF_W-1:0]  rsp_coeff_ff;
   logic                       rsp_last_ff;
   logic signed [COEFF_W-1:0]  sat_coeff;

   logic signed [SAMPLE_W-1:0] smp_rd;
   logic signed [COS_W-1:0]    cos_rd;
   logic [NUM_W-1:0]           quo;
   div_status_type             div_stat;

   assign req_stall = (st_ff != ST_LOAD);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Sample memory: written during loading, read once per cycle in the accumulate pass.
   cedct_store #(
      .POINTS (POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_take),
      .wr_addr (ld_cnt_ff),
      .wr_data (req_sample),
      .rd_addr (j_ff),
      .rd_data (smp_rd)
   );

   cedct_rom #(
      .POINTS (POINTS)
   ) u_rom (
      .clock (clock),
      .addr  (phase_ff),
      .data  (cos_rd)
   );

   // Rounding to nearest with ties away from zero: the magnitude gets half the divisor of
   // 2*D*2^16 added, the 2^16 part is dropped and the rest is divided by 2*D.
   assign rnd_sum = mag_ff + RND;

   cedct_div #(
      .NUM_W   (NUM_W),
      .DIVISOR (2 * D)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .numer    (rnd_sum[ACC_W-1:COS_FRAC]),
      .quotient (quo),
      .status   (div_stat)
   );

   // The table index steps by the coefficient index, so it walks (i*j) mod 2D without a
   // multiplier.
   always_comb begin
      phase_sum = (ROM_AW + 1)'(phase_ff) + (ROM_AW + 1)'(idx_ff);
      if (phase_sum >= (ROM_AW + 1)'(2 * D)) begin
         phase_in = ROM_AW'(phase_sum - (ROM_AW + 1)'(2 * D));
      end else begin
         phase_in = ROM_AW'(phase_sum);
      end
   end

   // The last sample counts positively for even coefficients and negatively for odd ones.
   assign ends = idx_ff[0] ? end_odd_ff : end_even_ff;

   always_comb begin
      if (neg_ff) begin
         sat_coeff = (quo > NUM_W'(SAT_NEG_MAG)) ? SAT_NEG
                                                 : COEFF_W'(16'd0 - quo[COEFF_W-1:0]);
      end else begin
         sat_coeff = (quo > NUM_W'(SAT_POS_MAG)) ? SAT_POS : COEFF_W'(quo[COEFF_W-1:0]);
      end
   end

   // Multiply and accumulate pipeline: memory read, product register, accumulator.
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(smp_rd) * PROD_W'(cos_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_LOAD;
         ld_cnt_ff    <= '0;
         issue_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= (st_ff == ST_MAC) && issue_ff;
         prod_vld_ff <= rd_vld_ff;
         // In the output state the register is reloaded below instead.
         if (rsp_valid_ff && !rsp_stall && (st_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (st_ff)
            ST_LOAD: begin
               if (req_take) begin
                  if (ld_cnt_ff == AW'(0)) begin
                     s0_ff <= req_sample;
                  end
                  if (ld_cnt_ff == AW'(D)) begin
                     end_even_ff <= END_W'(s0_ff) + END_W'(req_sample);
                     end_odd_ff  <= END_W'(s0_ff) - END_W'(req_sample);
                     ld_cnt_ff   <= '0;
                     idx_ff      <= '0;
                     j_ff        <= AW'(1);
                     phase_ff    <= '0;
                     issue_ff    <= 1'b1;
                     acc_ff      <= '0;
                     st_ff       <= ST_MAC;
                  end else begin
                     ld_cnt_ff <= ld_cnt_ff + AW'(1);
                  end
               end
            end

            ST_MAC: begin
               if (issue_ff) begin
                  j_ff     <= j_ff + AW'(1);
                  phase_ff <= phase_in;
                  if (j_ff == AW'(D - 1)) begin
                     issue_ff <= 1'b0;
                  end
               end
               if (prod_vld_ff) begin
                  acc_ff <= acc_ff + ACC_W'(prod_ff);
               end
               if (!issue_ff && !rd_vld_ff && !prod_vld_ff) begin
                  st_ff <= ST_FIN;
               end
            end

            ST_FIN: begin
               // Interior terms count twice; the end samples are scaled up to Q.16.
               acc_ff <= (acc_ff <<< 1) + (ACC_W'(ends) <<< COS_FRAC);
               st_ff  <= ST_ABS;
            end

            ST_ABS: begin
               if (!div_stat.busy) begin
                  neg_ff       <= acc_ff[ACC_W-1];
                  mag_ff       <= acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
                  div_start_ff <= 1'b1;
                  st_ff        <= ST_DIV;
               end
            end

            ST_DIV: begin
               div_start_ff <= 1'b0;
               if (div_stat.done) begin
                  st_ff <= ST_OUT;
               end
            end

            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_index_ff <= INDEX_W'(idx_ff);
                  rsp_coeff_ff <= sat_coeff;
                  rsp_last_ff  <= (idx_ff == AW'(D));
                  if (idx_ff == AW'(D)) begin
                     st_ff <= ST_LOAD;
                  end else begin
                     idx_ff   <= idx_ff + AW'(1);
                     j_ff     <= AW'(1);
                     phase_ff <= ROM_AW'(idx_ff) + ROM_AW'(1);
                     issue_ff <= 1'b1;
                     acc_ff   <= '0;
                     st_ff    <= ST_MAC;
                  end
               end
            end

            default: begin
               st_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coeff_index = rsp_index_ff;
   assign rsp_coefficient = rsp_coeff_ff;
   assign rsp_last_coeff  = rsp_last_ff;

endmodule
